// ===== design/mhd_pkg.sv =====
// Shared types, constants and the arctangent table for the magnetometer heading unit.
package mhd_pkg;

    // Widths of the CORDIC datapath: inputs carry 24 fraction bits.
    localparam int ACC_FRAC = 24;
    localparam int XY_W     = 43;
    localparam int ACC_W    = 34;
    localparam int TABLE_LEN = 24;

    localparam logic signed [15:0] OVERFLOW_CODE = -16'sd4096;
    localparam logic [14:0]        COURSE_FULL   = 15'd23040;

    // Configuration register map (byte address of each register).
    localparam logic [0:0] ADDR_COMPASS_EN = 1'b0;

    typedef logic signed [XY_W-1:0]  t_xy;
    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc ACC_P90  = t_acc'(90)  <<< ACC_FRAC;
    localparam t_acc ACC_M90  = -ACC_P90;
    localparam t_acc ACC_FULL = t_acc'(360) <<< ACC_FRAC;

    // atan(2^-i) in degrees, 24 fraction bits.
    localparam t_acc ATAN_Q24 [TABLE_LEN] = '{
        34'sd754974720, 34'sd445687602, 34'sd235489088, 34'sd119537938,
        34'sd60000934,  34'sd30029717,  34'sd15018523,  34'sd7509720,
        34'sd3754917,   34'sd1877466,   34'sd938734,    34'sd469367,
        34'sd234684,    34'sd117342,    34'sd58671,     34'sd29335,
        34'sd14668,     34'sd7334,      34'sd3667,      34'sd1833,
        34'sd917,       34'sd458,       34'sd229,       34'sd115
    };

    typedef enum logic [1:0] {
        SRC_COMPASS = 2'd0,
        SRC_GPS     = 2'd1,
        SRC_HELD    = 2'd2
    } t_src;

    typedef struct packed {
        logic signed [15:0] mag_x;
        logic signed [15:0] mag_y;
        logic signed [15:0] mag_z;
        logic [14:0]        gps_course;
        logic               gps_fix;
    } t_sample;

    typedef struct packed {
        logic [14:0] heading;
        logic        compass_ok;
        t_src        heading_source;
    } t_result;

    // State handed from one CORDIC cell to the next.
    typedef struct packed {
        logic vld;
        t_xy  x;
        t_xy  y;
        t_acc acc;
    } t_cell;

endpackage

// ===== design/mhd_stream_if.sv =====
// Valid/ready stream interface carrying one payload item.
interface mhd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/magnetometer_heading_unit.sv =====
// Magnetometer heading unit: CORDIC atan2 heading with GPS course fallback.
//
// One sample is processed at a time. An accepted sample enters a chain of
// CORDIC_ITERATIONS registered cells, one micro-rotation per cell; the
// heading is then registered in a holding register and moved on to the
// output register. The input stays closed while the chain runs and while the
// result waits in the holding register to move into the output register. A
// finished result waits in a holding register and the output register, so
// the next sample can be taken while the previous result is still unread.
// Heading is degrees times 2^HEADING_FRAC_BITS; on a failed compass read
// (compass disabled or any axis at -4096) the GPS course is used when there
// is a fix, otherwise the last heading is held. compass_enabled is the only
// register (address 0); the user must write it only while the unit is idle,
// and the block itself does not enforce this.
module magnetometer_heading_unit #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int HEADING_FRAC_BITS = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mhd_stream_if.sink   i_sample,
    mhd_stream_if.source o_result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW  = mhd_pkg::ACC_W;
    localparam int RSH = mhd_pkg::ACC_FRAC - HEADING_FRAC_BITS;
    localparam int SHL = (HEADING_FRAC_BITS >= 6) ? HEADING_FRAC_BITS - 6 : 0;
    localparam int SHR = (HEADING_FRAC_BITS >= 6) ? 0 : 6 - HEADING_FRAC_BITS;
    localparam logic [AW-1:0] HALF = AW'(1) << (RSH - 1);
    localparam logic [AW-1:0] LIM  = AW'(360) << HEADING_FRAC_BITS;

    mhd_pkg::t_sample smp;
    mhd_pkg::t_cell   chain [CORDIC_ITERATIONS+1];
    mhd_pkg::t_cell   last_cell;

    logic              accept;
    logic              cfg_wr;
    logic              compass_ok;
    logic              vec_zero;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic signed [16:0] px;
    logic signed [16:0] py;
    mhd_pkg::t_acc     pacc;
    logic [14:0]       course_red;
    logic [24:0]       course_wide;
    logic [14:0]       course_h;
    mhd_pkg::t_acc     acc_pos;
    logic [AW-1:0]     rnd;
    logic [AW-1:0]     rsh;
    logic [AW-1:0]     rwrap;
    logic [14:0]       n_heading;
    mhd_pkg::t_src     n_src;
    logic              take_out;

    logic              r_cfg_en;
    logic              r_busy;
    logic              r_pend;
    logic              r_out_vld;
    logic              r_ok;
    logic              r_zero;
    logic              r_fix;
    logic [14:0]       r_course_h;
    logic [14:0]       r_last;
    mhd_pkg::t_result  r_res;
    mhd_pkg::t_result  r_out;

    assign smp    = i_sample.data;
    assign accept = i_sample.valid && i_sample.ready;
    assign i_sample.ready = !r_busy && !r_pend;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == mhd_pkg::ADDR_COMPASS_EN);
    assign prdata = (paddr == mhd_pkg::ADDR_COMPASS_EN) ? {31'b0, r_cfg_en} : 32'b0;

    // ---- request decode ----
    assign compass_ok = r_cfg_en && (smp.mag_x != mhd_pkg::OVERFLOW_CODE)
                        && (smp.mag_y != mhd_pkg::OVERFLOW_CODE)
                        && (smp.mag_z != mhd_pkg::OVERFLOW_CODE);
    assign vec_zero   = (smp.mag_x == 16'sd0) && (smp.mag_y == 16'sd0);

    assign ax = 17'(smp.mag_x);
    assign ay = 17'(smp.mag_y);

    // left half plane: rotate by +-90 degrees first
    always_comb begin
        if (ax < 0) begin
            if (ay >= 0) begin
                px   = ay;
                py   = -ax;
                pacc = mhd_pkg::ACC_P90;
            end else begin
                px   = -ay;
                py   = ax;
                pacc = mhd_pkg::ACC_M90;
            end
        end else begin
            px   = ax;
            py   = ay;
            pacc = '0;
        end
    end

    assign chain[0].vld = accept;
    assign chain[0].x   = {{(mhd_pkg::XY_W - 17 - mhd_pkg::ACC_FRAC){px[16]}}, px,
                           {mhd_pkg::ACC_FRAC{1'b0}}};
    assign chain[0].y   = {{(mhd_pkg::XY_W - 17 - mhd_pkg::ACC_FRAC){py[16]}}, py,
                           {mhd_pkg::ACC_FRAC{1'b0}}};
    assign chain[0].acc = pacc;

    genvar g;
    generate
        for (g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
            mhd_cordic_cell #(
                .STEP (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_prev  (chain[g]),
                .o_next  (chain[g+1])
            );
        end
    endgenerate

    assign last_cell = chain[CORDIC_ITERATIONS];

    // ---- GPS course rescale ----
    assign course_red  = (smp.gps_course >= mhd_pkg::COURSE_FULL)
                         ? smp.gps_course - mhd_pkg::COURSE_FULL : smp.gps_course;
    assign course_wide = ({10'b0, course_red} << SHL) >> SHR;
    assign course_h    = course_wide[14:0];

    // ---- angle to heading ----
    assign acc_pos = (last_cell.acc < 0) ? last_cell.acc + mhd_pkg::ACC_FULL
                                         : last_cell.acc;
    assign rnd     = AW'(acc_pos) + HALF;
    assign rsh     = rnd >> RSH;
    assign rwrap   = (rsh >= LIM) ? rsh - LIM : rsh;

    always_comb begin
        if (r_ok) begin
            n_heading = r_zero ? 15'd0 : rwrap[14:0];
            n_src     = mhd_pkg::SRC_COMPASS;
        end else if (r_fix) begin
            n_heading = r_course_h;
            n_src     = mhd_pkg::SRC_GPS;
        end else begin
            n_heading = r_last;
            n_src     = mhd_pkg::SRC_HELD;
        end
    end

    assign take_out = r_pend && (!r_out_vld || o_result.ready);

    // ---- control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en  <= 1'b0;
            r_busy    <= 1'b0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_last    <= '0;
        end else begin
            if (cfg_wr) begin
                r_cfg_en <= pwdata[0];
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (last_cell.vld) begin
                r_busy <= 1'b0;
            end
            if (last_cell.vld) begin
                r_pend <= 1'b1;
                if (r_ok || r_fix) begin
                    r_last <= n_heading;
                end
            end else if (take_out) begin
                r_pend <= 1'b0;
            end
            if (take_out) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok       <= compass_ok;
            r_zero     <= vec_zero;
            r_fix      <= smp.gps_fix;
            r_course_h <= course_h;
        end
        if (last_cell.vld) begin
            r_res.heading        <= n_heading;
            r_res.compass_ok     <= r_ok;
            r_res.heading_source <= n_src;
        end
        if (take_out) begin
            r_out <= r_res;
        end
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

endmodule

// ===== design/mhd_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation, registered, fixed shift per cell.
module mhd_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mhd_pkg::t_cell       i_prev,
    output mhd_pkg::t_cell       o_next
);

    mhd_pkg::t_xy  dx;
    mhd_pkg::t_xy  dy;
    mhd_pkg::t_xy  n_x;
    mhd_pkg::t_xy  n_y;
    mhd_pkg::t_acc n_acc;
    logic          r_vld;
    mhd_pkg::t_xy  r_x;
    mhd_pkg::t_xy  r_y;
    mhd_pkg::t_acc r_acc;

    // arithmetic shifts floor toward minus infinity
    assign dx = i_prev.y >>> STEP;
    assign dy = i_prev.x >>> STEP;

    always_comb begin
        if (i_prev.y > 0) begin
            n_x   = i_prev.x + dx;
            n_y   = i_prev.y - dy;
            n_acc = i_prev.acc + mhd_pkg::ATAN_Q24[STEP];
        end else begin
            n_x   = i_prev.x - dx;
            n_y   = i_prev.y + dy;
            n_acc = i_prev.acc - mhd_pkg::ATAN_Q24[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_prev.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_next.vld = r_vld;
    assign o_next.x   = r_x;
    assign o_next.y   = r_y;
    assign o_next.acc = r_acc;

endmodule

// ===== dv/mhd_heading_checker.sv =====
// Checker for the magnetometer heading unit: predicts each heading and compares it with the result.
module mhd_heading_checker #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int HEADING_FRAC_BITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_sample_valid,
    input  logic                 i_sample_ready,
    input  mhd_pkg::t_sample     i_sample,
    input  logic                 i_result_valid,
    input  logic                 i_result_ready,
    input  mhd_pkg::t_result     i_result,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [0:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic [31:0]          i_prdata,
    input  logic                 i_pready,
    output int                   o_errors,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     ANGLE_FRAC    = 24;
    localparam int     STEP_COUNT    = 24;
    localparam longint QUARTER_TURN  = 64'sd90 <<< ANGLE_FRAC;
    localparam longint FULL_TURN     = 64'sd360 <<< ANGLE_FRAC;
    localparam logic signed [15:0] MAG_SATURATED = -16'sd4096;
    localparam longint COURSE_WRAP   = 23040;

    // atan(2^-i) in degrees with 24 fraction bits
    localparam longint ARCTAN_STEP [STEP_COUNT] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic              compass_on;
    logic [14:0]       last_heading;
    mhd_pkg::t_result  expected_headings[$];
    int                failures = 0;

    assign o_errors = failures;

    function automatic longint cordic_bearing(longint xin, longint yin);
        longint x, y, t, dx, dy, r;
        longint acc = 0;
        if (xin == 0 && yin == 0) begin
            return 0;
        end
        x = xin * (64'sd1 <<< ANGLE_FRAC);
        y = yin * (64'sd1 <<< ANGLE_FRAC);
        // left half plane: pre-rotate by +-90 degrees
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                acc = QUARTER_TURN;
            end else begin
                x = -y;
                y = t;
                acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < STEP_COUNT; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                acc = acc + ARCTAN_STEP[i];
            end else begin
                x = x - dx;
                y = y + dy;
                acc = acc - ARCTAN_STEP[i];
            end
        end
        if (acc < 0) begin
            acc = acc + FULL_TURN;
        end
        r = (acc + (64'sd1 <<< (ANGLE_FRAC - HEADING_FRAC_BITS - 1)))
            >>> (ANGLE_FRAC - HEADING_FRAC_BITS);
        if (r >= (64'sd360 <<< HEADING_FRAC_BITS)) begin
            r = r - (64'sd360 <<< HEADING_FRAC_BITS);
        end
        return r;
    endfunction

    function automatic logic [14:0] course_heading(logic [14:0] course);
        longint v;
        v = longint'(course);
        if (v >= COURSE_WRAP) begin
            v = v - COURSE_WRAP;
        end
        if (HEADING_FRAC_BITS >= 6) begin
            v = v << (HEADING_FRAC_BITS - 6);
        end else begin
            v = v >> (6 - HEADING_FRAC_BITS);
        end
        return v[14:0];
    endfunction

    // updates the held heading as the block does
    function automatic mhd_pkg::t_result heading_for_sample(mhd_pkg::t_sample s);
        mhd_pkg::t_result res;
        longint           bearing;
        logic             ok;
        ok = compass_on && s.mag_x != MAG_SATURATED && s.mag_y != MAG_SATURATED
             && s.mag_z != MAG_SATURATED;
        if (ok) begin
            bearing = cordic_bearing(longint'($signed(s.mag_x)), longint'($signed(s.mag_y)));
            last_heading = bearing[14:0];
            res.heading_source = mhd_pkg::SRC_COMPASS;
        end else if (s.gps_fix) begin
            last_heading = course_heading(s.gps_course);
            res.heading_source = mhd_pkg::SRC_GPS;
        end else begin
            res.heading_source = mhd_pkg::SRC_HELD;
        end
        res.heading = last_heading;
        res.compass_ok = ok;
        return res;
    endfunction

    task automatic check_result(mhd_pkg::t_result got);
        mhd_pkg::t_result want;
        if (expected_headings.size() == 0) begin
            failures++;
            $display("%0t: unexpected result heading %0d ok %0d source %0d", $time,
                     got.heading, got.compass_ok, got.heading_source);
            return;
        end
        want = expected_headings.pop_front();
        if (got.heading !== want.heading) begin
            failures++;
            $display("%0t: heading expected %0d actual %0d", $time, want.heading, got.heading);
        end
        if (got.compass_ok !== want.compass_ok) begin
            failures++;
            $display("%0t: compass_ok expected %0d actual %0d", $time,
                     want.compass_ok, got.compass_ok);
        end
        if (got.heading_source !== want.heading_source) begin
            failures++;
            $display("%0t: heading_source expected %0d actual %0d", $time,
                     want.heading_source, got.heading_source);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            compass_on = 1'b0;
            last_heading = '0;
            expected_headings.delete();
            o_pending = 0;
        end else begin
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    if (i_paddr == mhd_pkg::ADDR_COMPASS_EN) begin
                        compass_on = i_pwdata[0];
                    end
                end else if (i_prdata !== {31'b0, compass_on}) begin
                    failures++;
                    $display("%0t: register read expected %0d actual %0h", $time,
                             compass_on, i_prdata);
                end
            end
            if (i_result_valid && i_result_ready) begin
                check_result(i_result);
            end
            if (i_sample_valid && i_sample_ready) begin
                expected_headings.push_back(heading_for_sample(i_sample));
            end
            o_pending = expected_headings.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the magnetometer heading unit: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITERS        = 16;
    localparam int FRAC         = 6;
    localparam int SETTLE       = ITERS + 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASES       = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel, penable, pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          in_flight;
    int          idle_cycles = 0;
    int          requests_sent = 0;
    int          results_taken = 0;

    mhd_stream_if #(.T(mhd_pkg::t_sample)) sample_if ();
    mhd_stream_if #(.T(mhd_pkg::t_result)) result_if ();

    always #2 i_clk = ~i_clk;

    magnetometer_heading_unit #(
        .CORDIC_ITERATIONS(ITERS),
        .HEADING_FRAC_BITS(FRAC)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mhd_heading_checker #(
        .CORDIC_ITERATIONS(ITERS),
        .HEADING_FRAC_BITS(FRAC)
    ) heading_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (sample_if.valid),
        .i_sample_ready (sample_if.ready),
        .i_sample       (sample_if.data),
        .i_result_valid (result_if.valid),
        .i_result_ready (result_if.ready),
        .i_result       (result_if.data),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_errors       (mismatches),
        .o_pending      (in_flight)
    );

    function automatic int draw_wait(bit calm);
        return calm ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic mhd_pkg::t_sample mk(logic signed [15:0] x, logic signed [15:0] y,
                                            logic signed [15:0] z, int course, bit fix);
        mhd_pkg::t_sample s;
        s.mag_x = x;
        s.mag_y = y;
        s.mag_z = z;
        s.gps_course = 15'(course);
        s.gps_fix = fix;
        return s;
    endfunction

    function automatic logic signed [15:0] extreme_axis();
        case ($urandom_range(0, 3))
            0: return 16'sh7fff;
            1: return -16'sd32768;
            2: return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic mhd_pkg::t_sample random_request();
        mhd_pkg::t_sample s;
        int               kind;
        kind = $urandom_range(0, 99);
        s.mag_x = 16'($urandom());
        s.mag_y = 16'($urandom());
        s.mag_z = 16'($urandom());
        if (kind >= 60 && kind < 75) begin
            s.mag_x = 16'($signed($urandom_range(0, 64)) - 32);
            s.mag_y = 16'($signed($urandom_range(0, 64)) - 32);
        end else if (kind >= 75 && kind < 85) begin
            // on an axis or a diagonal
            case ($urandom_range(0, 3))
                0: s.mag_x = '0;
                1: s.mag_y = '0;
                2: s.mag_y = s.mag_x;
                default: s.mag_y = -s.mag_x;
            endcase
        end else if (kind >= 85 && kind < 95) begin
            case ($urandom_range(0, 2))
                0: s.mag_x = mhd_pkg::OVERFLOW_CODE;
                1: s.mag_y = mhd_pkg::OVERFLOW_CODE;
                default: s.mag_z = mhd_pkg::OVERFLOW_CODE;
            endcase
        end else if (kind >= 95) begin
            s.mag_x = extreme_axis();
            s.mag_y = extreme_axis();
        end
        s.gps_course = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(23040, 32767))
                                                   : 15'($urandom_range(0, 23039));
        s.gps_fix = 1'($urandom_range(0, 1));
        return s;
    endfunction

    // called and returns at a falling edge
    task automatic send_request(mhd_pkg::t_sample s);
        int gap;
        gap = draw_wait((requests_sent / 40) % 4 == 0);
        if (gap > 0) begin
            sample_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_if.data = s;
        sample_if.valid = 1'b1;
        @(posedge i_clk);
        while (!sample_if.ready) @(posedge i_clk);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic end_of_phase();
        sample_if.valid = 1'b0;
        while (in_flight != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_access(bit write, bit value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = mhd_pkg::ADDR_COMPASS_EN;
        pwdata = {31'($urandom()), value};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_compass(bit enable);
        apb_access(1'b1, enable);
        apb_access(1'b0, 1'b0);
    endtask

    // result side: random stall before each result, none in the calm stretches
    initial begin
        int stall;
        result_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            stall = draw_wait((results_taken / 48) % 4 == 1);
            if (stall > 0) begin
                result_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            result_if.ready = 1'b1;
            @(posedge i_clk);
            while (!result_if.valid) @(posedge i_clk);
            results_taken++;
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (sample_if.valid && sample_if.ready)
            || (result_if.valid && result_if.ready) || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        sample_if.valid = 1'b0;
        sample_if.data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // compass off: GPS course, course wrap and held heading
        set_compass(1'b0);
        send_request(mk(100, 200, 0, 0, 1'b1));
        send_request(mk(0, 0, 0, 23039, 1'b1));
        send_request(mk(5, 5, 5, 23040, 1'b1));
        send_request(mk(5, 5, 5, 32767, 1'b1));
        send_request(mk(-1, -1, -1, 12345, 1'b0));
        end_of_phase();

        // compass on: zero vector, axis extremes, quadrants, overflow on each axis
        set_compass(1'b1);
        send_request(mk(0, 0, 0, 0, 1'b0));
        send_request(mk(16'sh7fff, 0, 0, 0, 1'b0));
        send_request(mk(-16'sd32768, 0, 0, 0, 1'b0));
        send_request(mk(0, 16'sh7fff, 0, 0, 1'b0));
        send_request(mk(0, -16'sd32768, 0, 0, 1'b0));
        send_request(mk(16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 1'b1));
        send_request(mk(-16'sd32768, -16'sd32768, -16'sd32768, 32767, 1'b1));
        send_request(mk(-16'sd32768, 16'sh7fff, 0, 0, 1'b0));
        send_request(mk(16'sh7fff, -16'sd32768, 0, 0, 1'b0));
        send_request(mk(-1, 0, 0, 0, 1'b0));
        send_request(mk(-1, -1, 0, 0, 1'b0));
        send_request(mk(1, -1, 0, 0, 1'b0));
        send_request(mk(mhd_pkg::OVERFLOW_CODE, 5, 5, 1000, 1'b1));
        send_request(mk(5, mhd_pkg::OVERFLOW_CODE, 5, 2000, 1'b0));
        send_request(mk(5, 5, mhd_pkg::OVERFLOW_CODE, 32767, 1'b1));
        send_request(mk(mhd_pkg::OVERFLOW_CODE, mhd_pkg::OVERFLOW_CODE,
                        mhd_pkg::OVERFLOW_CODE, 0, 1'b0));
        send_request(mk(-16'sd4095, 16'sd4095, -16'sd4097, 0, 1'b0));
        end_of_phase();

        for (int phase = 0; phase < PHASES; phase++) begin
            set_compass(phase % 3 != 2);
            repeat (RANDOM_ITEMS / PHASES) send_request(random_request());
            end_of_phase();
        end

        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
